// ===== sv/aabbfc_pkg.sv =====
// Shared types and widths for the box versus frustum cull pipeline.
`default_nettype none
package aabbfc_pkg;

    localparam int NUM_PLANE_REGS = 6;
    localparam int ADDR_W         = 6;
    localparam int IDX_W          = 3;
    localparam int IDX_LSB        = 3;
    localparam int DATA_W         = 64;

    localparam int NORMAL_W   = 13;
    localparam int NORMAL_FRAC = 11;
    localparam int OFFSET_W   = 25;
    localparam int OFFSET_LSB = 39;
    localparam int CENTER_W   = 24;
    localparam int HALF_W     = 23;

    localparam int CN_W = CENTER_W + NORMAL_W;   // center * normal, signed
    localparam int HN_W = HALF_W + NORMAL_W;     // half * |normal|, unsigned
    localparam int D_W  = CN_W + 3;              // distance sum, signed
    localparam int R_W  = HN_W + 2;              // radius sum, unsigned
    localparam int S_W  = D_W + 1;               // final compare sum, signed

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 8;

    typedef logic signed [CENTER_W-1:0] t_center;
    typedef logic        [HALF_W-1:0]   t_half;
    typedef logic signed [NORMAL_W-1:0] t_normal;
    typedef logic        [NORMAL_W-1:0] t_nmag;
    typedef logic signed [OFFSET_W-1:0] t_offset;
    typedef logic signed [CN_W-1:0]     t_cn;
    typedef logic        [HN_W-1:0]     t_hn;
    typedef logic signed [D_W-1:0]      t_dsum;
    typedef logic        [R_W-1:0]      t_rsum;
    typedef logic signed [S_W-1:0]      t_psum;
    typedef logic        [DATA_W-1:0]   t_plane;

    typedef struct packed {
        t_half   hz;
        t_half   hy;
        t_half   hx;
        t_center cz;
        t_center cy;
        t_center cx;
    } t_box;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_stage_en;

endpackage
`default_nettype wire

// ===== sv/aabbfc_regs.sv =====
// APB register file holding the six plane registers.
`default_nettype none
module aabbfc_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [aabbfc_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [aabbfc_pkg::DATA_W-1:0]        pwdata,
    output      logic [aabbfc_pkg::DATA_W-1:0]        prdata,
    output      logic                                 pready,
    output      aabbfc_pkg::t_plane [aabbfc_pkg::NUM_PLANE_REGS-1:0] o_planes
);

    aabbfc_pkg::t_plane [aabbfc_pkg::NUM_PLANE_REGS-1:0] r_planes;
    logic [aabbfc_pkg::IDX_W-1:0] w_idx;
    logic                         w_hit;

    assign w_idx  = paddr[aabbfc_pkg::IDX_LSB +: aabbfc_pkg::IDX_W];
    assign w_hit  = (w_idx < aabbfc_pkg::IDX_W'(aabbfc_pkg::NUM_PLANE_REGS));
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (psel && penable && pwrite && w_hit) begin
            r_planes[w_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = r_planes[w_idx];
        end
    end

    assign o_planes = r_planes;

endmodule
`default_nettype wire

// ===== sv/aabbfc_plane.sv =====
// Three-stage datapath for one plane: products, partial sums, sign test.
`default_nettype none
module aabbfc_plane (
    input  wire logic                  i_clk,
    input  wire aabbfc_pkg::t_plane    i_plane,
    input  wire aabbfc_pkg::t_box      i_box,
    input  wire aabbfc_pkg::t_stage_en i_en,
    output      logic                  o_pass
);

    aabbfc_pkg::t_normal w_n [3];
    aabbfc_pkg::t_nmag   w_nmag [3];
    aabbfc_pkg::t_center w_c [3];
    aabbfc_pkg::t_half   w_h [3];
    aabbfc_pkg::t_offset w_off;

    aabbfc_pkg::t_cn     r_cn [3];
    aabbfc_pkg::t_hn     r_hn [3];
    aabbfc_pkg::t_offset r_off;
    aabbfc_pkg::t_dsum   r_dsum;
    aabbfc_pkg::t_rsum   r_rsum;
    logic                r_pass;

    aabbfc_pkg::t_dsum   n_dsum;
    aabbfc_pkg::t_rsum   n_rsum;
    aabbfc_pkg::t_psum   n_psum;

    assign w_c[0] = i_box.cx;
    assign w_c[1] = i_box.cy;
    assign w_c[2] = i_box.cz;
    assign w_h[0] = i_box.hx;
    assign w_h[1] = i_box.hy;
    assign w_h[2] = i_box.hz;
    assign w_off  = i_plane[aabbfc_pkg::OFFSET_LSB +: aabbfc_pkg::OFFSET_W];

    // |n| of the most negative code still fits as an unsigned value
    for (genvar k = 0; k < 3; k++) begin : g_axis
        assign w_n[k]    = i_plane[k*aabbfc_pkg::NORMAL_W +: aabbfc_pkg::NORMAL_W];
        assign w_nmag[k] = w_n[k][aabbfc_pkg::NORMAL_W-1] ? aabbfc_pkg::t_nmag'(-w_n[k])
                                                           : aabbfc_pkg::t_nmag'(w_n[k]);

        always_ff @(posedge i_clk) begin
            if (i_en.en1) begin
                r_cn[k] <= aabbfc_pkg::t_cn'(w_c[k]) * aabbfc_pkg::t_cn'(w_n[k]);
                r_hn[k] <= aabbfc_pkg::t_hn'(w_h[k]) * aabbfc_pkg::t_hn'(w_nmag[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_off <= w_off;
        end
    end

    always_comb begin
        n_dsum = (aabbfc_pkg::t_dsum'(r_off) <<< aabbfc_pkg::NORMAL_FRAC)
               + aabbfc_pkg::t_dsum'(r_cn[0])
               + aabbfc_pkg::t_dsum'(r_cn[1])
               + aabbfc_pkg::t_dsum'(r_cn[2]);
        n_rsum = aabbfc_pkg::t_rsum'(r_hn[0])
               + aabbfc_pkg::t_rsum'(r_hn[1])
               + aabbfc_pkg::t_rsum'(r_hn[2]);
        // -r <= d  is  d + r >= 0
        n_psum = aabbfc_pkg::t_psum'(r_dsum) + aabbfc_pkg::t_psum'(r_rsum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_dsum <= n_dsum;
            r_rsum <= n_rsum;
        end
        if (i_en.en3) begin
            r_pass <= ~n_psum[aabbfc_pkg::S_W-1];
        end
    end

    assign o_pass = r_pass;

endmodule
`default_nettype wire

// ===== sv/aabb_frustum_cull_test.sv =====
// Top level: box versus frustum cull test, stream in, stream out, APB planes.
//
// One box per input item on s_axis; one result item on m_axis for each box,
// in order. Plane registers are written over the APB port at byte address
// 8*i (plane 0 near, 1 far, 2..5 sides); the user writes only while the
// pipe is empty, which the block does not enforce. A plane word packs nx,
// ny, nz (signed Q1.11) and an offset (signed Q16.8). Only planes 0 ..
// PLANE_COUNT-1 take part in the test. Pipeline: products, partial sums,
// per-plane sign test, then the AND of all planes into the output register.
// Throughput is one box per cycle while the output is not stalled; each
// stage has its own valid bit and takes new data when it is empty or its
// successor moves, so bubbles close up and input can still be taken while
// the output waits. When m_axis_tready is low the output holds and the
// stages fill behind it; s_axis_tready drops only once every stage is full.
// Reset (synchronous, active low) empties the pipe and clears all planes to
// zero; with all-zero planes every box is reported inside.
`default_nettype none
module aabb_frustum_cull_test #(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // low to high: center_x, center_y, center_z, half_x, half_y, half_z, pad[143:141]
    input  wire logic [aabbfc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                                 s_axis_tvalid,
    output      logic                                 s_axis_tready,
    // low to high: inside_res, pad[7:1]
    output      logic [aabbfc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output      logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [aabbfc_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [aabbfc_pkg::DATA_W-1:0]        pwdata,
    output      logic [aabbfc_pkg::DATA_W-1:0]        prdata,
    output      logic                                 pready
);

    aabbfc_pkg::t_plane [aabbfc_pkg::NUM_PLANE_REGS-1:0] w_planes;
    aabbfc_pkg::t_box      w_box;
    aabbfc_pkg::t_stage_en w_en;
    logic [PLANE_COUNT-1:0] w_pass;

    logic r_v1, r_v2, r_v3, r_vo;
    logic r_inside;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdyo;

    aabbfc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_planes (w_planes)
    );

    assign w_box = aabbfc_pkg::t_box'(s_axis_tdata[$bits(aabbfc_pkg::t_box)-1:0]);

    assign w_rdyo = !r_vo || m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdyo;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign s_axis_tready = w_rdy1;
    assign w_en.en1 = w_rdy1;
    assign w_en.en2 = w_rdy2;
    assign w_en.en3 = w_rdy3;

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        aabbfc_plane u_plane (
            .i_clk   (i_clk),
            .i_plane (w_planes[p]),
            .i_box   (w_box),
            .i_en    (w_en),
            .o_pass  (w_pass[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdyo) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdyo) begin
            r_inside <= &w_pass;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = aabbfc_pkg::OUT_TDATA_W'(r_inside);

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3 && !r_vo))
        else $error("pipeline not empty after reset");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> s_axis_tready)
        else $error("input stalled with first stage empty");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted item lost at first stage");

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (!r_vo || m_axis_tready)) |=> r_vo)
        else $error("item lost between sign test and output");
`endif

endmodule
`default_nettype wire
